FILE: rtl/core/urbrx_pkg.sv
// Package for the UART register block with receive FIFO.
// Holds command and register codes, reset constants and item structs.
// No dependencies.
`default_nettype none

package urbrx_pkg;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RECV  = 2'd2;

  // Register addresses
  localparam logic [1:0] REG_DATA     = 2'd0;
  localparam logic [1:0] REG_PRESC_HI = 2'd1;
  localparam logic [1:0] REG_FRAMING  = 2'd2;
  localparam logic [1:0] REG_STATUS   = 2'd3;

  // Parity modes
  localparam logic [1:0] PAR_OFF       = 2'd0;
  localparam logic [1:0] PAR_EVEN_MODE = 2'd1;
  localparam logic [1:0] PAR_ODD_MODE  = 2'd2;

  localparam logic [13:0] PRESC_LOW_RST = 14'd243;
  localparam logic [2:0]  PRESC_HI_RST  = 3'd0;
  localparam logic [7:0]  FRAMING_RST   = 8'h18;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_sel;
    logic [7:0] data_in;
    logic       tx_is_empty;
    logic       tx_is_full;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        tx_clear;
    logic [16:0] baud_divisor;
    logic [3:0]  data_bits;
    logic [1:0]  parity_mode;
    logic        rx_near_full;
  } result_t;

  // Result stage: result plus a flag that read_data comes from the FIFO memory
  typedef struct packed {
    result_t res;
    logic    is_pop;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/urbrx_req_if.sv
// Request channel: bus reads, bus writes and received bytes.
// Valid/ready handshake. No dependencies.
`default_nettype none

interface urbrx_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] reg_sel;
  logic [7:0] data_in;
  logic       tx_is_empty;
  logic       tx_is_full;

  modport source (output valid, cmd, reg_sel, data_in, tx_is_empty, tx_is_full,
                  input ready);
  modport sink   (input valid, cmd, reg_sel, data_in, tx_is_empty, tx_is_full,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/urbrx_rsp_if.sv
// Response channel: one result item per request item.
// Valid/ready handshake. No dependencies.
`default_nettype none

interface urbrx_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        tx_clear;
  logic [16:0] baud_divisor;
  logic [3:0]  data_bits;
  logic [1:0]  parity_mode;
  logic        rx_near_full;

  modport source (output valid, read_data, send_valid, send_byte, tx_clear,
                  baud_divisor, data_bits, parity_mode, rx_near_full,
                  input ready);
  modport sink   (input valid, read_data, send_valid, send_byte, tx_clear,
                  baud_divisor, data_bits, parity_mode, rx_near_full,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/urbrx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module urbrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/urbrx_regs.sv
// Register file and receive FIFO pointer control of the UART register block.
// Decodes one accepted item per cycle and drives the FIFO memory ports; uses urbrx_pkg.
`default_nettype none

module urbrx_regs
  import urbrx_pkg::*;
#(
  parameter int RX_DEPTH = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire in_item_t                    item,
  output result_t                          res,
  output logic                             pop,
  output logic                             ram_we,
  output logic [$clog2(RX_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(RX_DEPTH)-1:0]      ram_raddr
);

  localparam int AW   = $clog2(RX_DEPTH);
  localparam int NEAR = RX_DEPTH * 3 / 4;

  logic [AW-1:0] rx_head, rx_head_next;
  logic [AW-1:0] rx_tail, rx_tail_next;
  logic          rx_empty, rx_empty_next;
  logic          near_full, near_full_next;
  logic [13:0]   prescale_low, prescale_low_next;
  logic [2:0]    prescale_high, prescale_high_next;
  logic [7:0]    framing, framing_next;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW:0] occ(input logic [AW-1:0] t, input logic [AW-1:0] h);
    if (t >= h) return {1'b0, t} - {1'b0, h};
    else        return {1'b0, t} + (AW+1)'(RX_DEPTH) - {1'b0, h};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_empty      <= 1'b1;
      near_full     <= 1'b0;
      prescale_low  <= PRESC_LOW_RST;
      prescale_high <= PRESC_HI_RST;
      framing       <= FRAMING_RST;
    end else begin
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      rx_empty      <= rx_empty_next;
      near_full     <= near_full_next;
      prescale_low  <= prescale_low_next;
      prescale_high <= prescale_high_next;
      framing       <= framing_next;
    end
  end

  assign ram_waddr = rx_tail;
  assign ram_wdata = item.data_in;
  assign ram_raddr = rx_head;

  always_comb begin
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    rx_empty_next      = rx_empty;
    near_full_next     = near_full;
    prescale_low_next  = prescale_low;
    prescale_high_next = prescale_high;
    framing_next       = framing;
    res                = '0;
    pop                = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;

    if (accept) begin
      case (item.cmd)
        CMD_READ: begin
          unique case (item.reg_sel)
            REG_DATA: begin
              // empty FIFO reads zero and stays put
              if (!rx_empty) begin
                pop            = 1'b1;
                ram_re         = 1'b1;
                rx_head_next   = ptr_inc(rx_head);
                rx_empty_next  = (rx_head_next == rx_tail);
                near_full_next = occ(rx_tail, rx_head_next) >= (AW+1)'(NEAR);
              end
            end
            REG_PRESC_HI: res.read_data = {5'd0, prescale_high};
            REG_FRAMING:  res.read_data = framing;
            REG_STATUS: begin
              res.read_data = {3'd0, item.tx_is_empty, near_full,
                               (!rx_empty && (rx_head == rx_tail)),
                               item.tx_is_full, !rx_empty};
            end
            default: ;
          endcase
        end
        CMD_WRITE: begin
          unique case (item.reg_sel)
            REG_DATA: begin
              if (item.data_in[7]) prescale_low_next = {item.data_in[6:0], prescale_low[6:0]};
              else                 prescale_low_next = {prescale_low[13:7], item.data_in[6:0]};
            end
            REG_PRESC_HI: begin
              if (item.data_in[4]) prescale_high_next = item.data_in[2:0];
            end
            REG_FRAMING: begin
              if (item.data_in[7]) begin
                rx_head_next   = '0;
                rx_tail_next   = '0;
                rx_empty_next  = 1'b1;
                near_full_next = 1'b0;
                res.tx_clear   = 1'b1;
              end
              framing_next = item.data_in;
            end
            REG_STATUS: begin
              res.send_valid = 1'b1;
              res.send_byte  = item.data_in;
            end
            default: ;
          endcase
        end
        CMD_RECV: begin
          // a full FIFO overwrites the oldest byte and its tail moves past the head
          ram_we        = 1'b1;
          rx_tail_next  = ptr_inc(rx_tail);
          rx_empty_next = 1'b0;
          if (!near_full) begin
            near_full_next = occ(rx_tail_next, rx_head) >= (AW+1)'(NEAR);
          end
        end
        default: ;
      endcase
    end

    res.baud_divisor = {prescale_high_next, prescale_low_next};
    res.data_bits    = {2'b01, framing_next[4:3]} + 4'd1;
    if (framing_next[2]) res.parity_mode = framing_next[1] ? PAR_ODD_MODE : PAR_EVEN_MODE;
    else                 res.parity_mode = PAR_OFF;
    res.rx_near_full = near_full_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/uart_register_block_rx_fifo.sv
// Top level of the UART register block with receive FIFO.
// Uses urbrx_pkg, urbrx_req_if, urbrx_rsp_if, urbrx_regs and urbrx_ram.
//
//   channel  dir  contents
//   req      in   cmd, reg_sel, data_in, tx_is_empty, tx_is_full
//   rsp      out  read_data, send_valid, send_byte, tx_clear, baud_divisor,
//                 data_bits, parity_mode, rx_near_full
//
// One item per cycle sustained while rsp takes results; each result passes the result
// stage, which waits on the registered read port of the receive FIFO memory, then the output register.
// Reset clears pointers, flags and configuration at once; the FIFO memory has
// no clearing pass, since only entries written since the last clear are read.
// A stalled rsp holds the output register; req keeps flowing while the result
// stage can move on.
`default_nettype none

module uart_register_block_rx_fifo
  import urbrx_pkg::*;
#(
  parameter int RX_DEPTH = 512
) (
  input wire logic      clk,
  input wire logic      rst,
  urbrx_req_if.sink     req,
  urbrx_rsp_if.source   rsp
);

  localparam int AW = $clog2(RX_DEPTH);

  in_item_t      item;
  result_t       res;
  logic          pop;
  logic          accept;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          s1_valid;
  stage_t        s1;
  logic          s1_move;
  result_t       s1_out;
  logic          out_valid;
  result_t       out_res;

  assign item = '{cmd: req.cmd, reg_sel: req.reg_sel, data_in: req.data_in,
                  tx_is_empty: req.tx_is_empty, tx_is_full: req.tx_is_full};

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || s1_move);
  assign accept    = req.valid && req.ready;

  urbrx_regs #(.RX_DEPTH(RX_DEPTH)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .res       (res),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  urbrx_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result stage: wait for the memory read data of a pop
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= '{res: res, is_pop: pop};
    end
  end

  // a pop takes its byte from the memory read port
  always_comb begin
    s1_out = s1.res;
    if (s1.is_pop) begin
      s1_out.read_data = ram_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= s1_out;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_res.read_data;
  assign rsp.send_valid   = out_res.send_valid;
  assign rsp.send_byte    = out_res.send_byte;
  assign rsp.tx_clear     = out_res.tx_clear;
  assign rsp.baud_divisor = out_res.baud_divisor;
  assign rsp.data_bits    = out_res.data_bits;
  assign rsp.parity_mode  = out_res.parity_mode;
  assign rsp.rx_near_full = out_res.rx_near_full;

`ifndef NO_ASSERTIONS
  // a pop that reads the memory lands in the result stage flagged as such
  a_pop_tracked: assert property (@(posedge clk) disable iff (rst)
    (accept && ram_re) |=> (s1_valid && s1.is_pop))
    else $error("pop item not tracked into result stage");

  // one item never both writes and reads the FIFO memory
  a_one_ram_op: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("FIFO memory written and read by one item");

  // clearing the FIFOs also drops the near-full flag
  a_clear_near: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.res.tx_clear) |-> !s1.res.rx_near_full)
    else $error("near-full set on a clearing framing write");

  // a transmit write never carries read data
  a_send_no_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.send_valid) |-> (out_res.read_data == 8'd0))
    else $error("read data on a transmit item");
`endif

endmodule

`default_nettype wire

FILE: tb/uart_register_block_rx_fifo_tb.sv
// Testbench for the UART register block with receive FIFO.
// Drives urbrx_req_if items; checks every urbrx_rsp_if item against fixed
// values or a register/FIFO predictor. Needs urbrx_pkg and both interfaces.
`timescale 1ns / 100ps

module uart_register_block_rx_fifo_tb;
  import urbrx_pkg::*;

  localparam int FIFO_DEPTH = 512;
  localparam int NEAR_LEVEL = FIFO_DEPTH * 3 / 4;
  localparam int LONG_HOLD  = 300;
  localparam int LIMIT      = 1_000_000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    in_item_t item;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  urbrx_req_if req_ch ();
  urbrx_rsp_if rsp_ch ();

  uart_register_block_rx_fifo #(.RX_DEPTH(FIFO_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // Predicted register and FIFO state
  logic [7:0]  q_mem [FIFO_DEPTH];
  int          q_head;
  int          q_tail;
  bit          q_empty;
  bit          q_near;
  logic [13:0] div_lo;
  logic [2:0]  div_hi;
  logic [7:0]  frame_q;

  result_t  rsp_due [$];
  dir_row_t dir_rows [$];
  int       n_fail;
  int       cycle_count;
  int       hold_asked;
  int       hold_served;
  int       src_calm;
  int       snk_calm;

  function automatic int q_level();
    return (q_tail + FIFO_DEPTH - q_head) % FIFO_DEPTH;
  endfunction

  function automatic void q_clear();
    q_head  = 0;
    q_tail  = 0;
    q_empty = 1'b1;
    q_near  = 1'b0;
  endfunction

  function automatic result_t predict_uart(input in_item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CMD_READ: begin
        case (it.reg_sel)
          REG_DATA: begin
            // empty FIFO reads as zero and keeps its state
            if (!q_empty) begin
              r.read_data = q_mem[q_head];
              q_head  = (q_head + 1) % FIFO_DEPTH;
              q_empty = (q_head == q_tail);
              q_near  = q_level() >= NEAR_LEVEL;
            end
          end
          REG_PRESC_HI: r.read_data = {5'd0, div_hi};
          REG_FRAMING:  r.read_data = frame_q;
          default: begin
            r.read_data = {3'd0, it.tx_is_empty, q_near, !q_empty && (q_head == q_tail),
                           it.tx_is_full, !q_empty};
          end
        endcase
      end
      CMD_WRITE: begin
        case (it.reg_sel)
          REG_DATA: begin
            if (it.data_in[7]) div_lo[13:7] = it.data_in[6:0];
            else div_lo[6:0] = it.data_in[6:0];
          end
          REG_PRESC_HI: begin
            if (it.data_in[4]) div_hi = it.data_in[2:0];
          end
          REG_FRAMING: begin
            if (it.data_in[7]) begin
              q_clear();
              r.tx_clear = 1'b1;
            end
            frame_q = it.data_in;
          end
          default: begin
            r.send_valid = 1'b1;
            r.send_byte  = it.data_in;
          end
        endcase
      end
      CMD_RECV: begin
        // a full FIFO overwrites its oldest entry and its tail moves past the head
        q_mem[q_tail] = it.data_in;
        q_tail  = (q_tail + 1) % FIFO_DEPTH;
        q_empty = 1'b0;
        if (!q_near) q_near = q_level() >= NEAR_LEVEL;
      end
      default: ;
    endcase
    r.baud_divisor = {div_hi, div_lo};
    r.data_bits    = 4'd5 + 4'(frame_q[4:3]);
    r.parity_mode  = !frame_q[2] ? PAR_OFF : (frame_q[1] ? PAR_ODD_MODE : PAR_EVEN_MODE);
    r.rx_near_full = q_near;
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] c, input logic [1:0] s,
                                       input logic [7:0] d, input logic e, input logic f);
    in_item_t it;
    it.cmd         = c;
    it.reg_sel     = s;
    it.data_in     = d;
    it.tx_is_empty = e;
    it.tx_is_full  = f;
    return it;
  endfunction

  function automatic result_t reset_res(input logic [7:0] rd);
    result_t r;
    r              = '0;
    r.read_data    = rd;
    r.baud_divisor = {PRESC_HI_RST, PRESC_LOW_RST};
    r.data_bits    = 4'd8;
    r.parity_mode  = PAR_OFF;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = 40;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t rand_item(input int recv_pct, input bit quiet);
    in_item_t it;
    it = mk_item(CMD_RECV, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) >= recv_pct) begin
      case ($urandom_range(0, 9))
        0:          it.cmd = CMD_NONE;
        1, 2, 3, 4: it.cmd = CMD_READ;
        default:    it.cmd = CMD_WRITE;
      endcase
      // keep the fill level moving one way: no pops, no clears
      if (quiet && ((it.cmd == CMD_READ && it.reg_sel == REG_DATA) ||
                    (it.cmd == CMD_WRITE && it.reg_sel == REG_FRAMING)))
        it.reg_sel = REG_STATUS;
    end
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed = 1'b0, input result_t want = '0);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic offer(input in_item_t it, input bit typed = 1'b0, input result_t want = '0);
    result_t pred;
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= it.cmd;
    req_ch.reg_sel     <= it.reg_sel;
    req_ch.data_in     <= it.data_in;
    req_ch.tx_is_empty <= it.tx_is_empty;
    req_ch.tx_is_full  <= it.tx_is_full;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = predict_uart(it);
    rsp_due.push_back(typed ? want : pred);
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    req_ch.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic mixed_burst(input int n);
    repeat (n) offer(rand_item(35, 1'b0));
  endtask

  task automatic pop_burst(input int n);
    repeat (n) begin
      offer(mk_item(CMD_READ, ($urandom_range(0, 4) == 0) ? REG_STATUS : REG_DATA,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
    end
  endtask

  // Clear the FIFO, then receive lo..hi bytes with a little noise in between
  task automatic fill_fifo(input int lo, input int hi);
    in_item_t it;
    int n_recv;
    int target;
    offer(mk_item(CMD_WRITE, REG_FRAMING, 8'h80 | 8'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    n_recv = 0;
    target = $urandom_range(lo, hi);
    while (n_recv < target) begin
      it = rand_item(98, 1'b1);
      if (it.cmd == CMD_RECV) n_recv++;
      offer(it);
    end
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : rsp_monitor
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_due.size() == 0) begin
        $error("result item with nothing expected");
        n_fail++;
      end else begin
        want = rsp_due.pop_front();
        check_field("read_data", want.read_data, rsp_ch.read_data);
        check_field("send_valid", want.send_valid, rsp_ch.send_valid);
        check_field("send_byte", want.send_byte, rsp_ch.send_byte);
        check_field("tx_clear", want.tx_clear, rsp_ch.tx_clear);
        check_field("baud_divisor", want.baud_divisor, rsp_ch.baud_divisor);
        check_field("data_bits", want.data_bits, rsp_ch.data_bits);
        check_field("parity_mode", want.parity_mode, rsp_ch.parity_mode);
        check_field("rx_near_full", want.rx_near_full, rsp_ch.rx_near_full);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Response side: random stalls, plus a long hold whenever one is requested
  initial begin : rsp_sink
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap(snk_calm);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_READ;
    req_ch.reg_sel     <= REG_DATA;
    req_ch.data_in     <= 8'd0;
    req_ch.tx_is_empty <= 1'b0;
    req_ch.tx_is_full  <= 1'b0;

    for (int i = 0; i < FIFO_DEPTH; i++) q_mem[i] = 8'd0;
    q_clear();
    div_lo  = PRESC_LOW_RST;
    div_hi  = PRESC_HI_RST;
    frame_q = FRAMING_RST;

    // values right after reset, read of an empty FIFO, unused command
    add_row(mk_item(CMD_READ, REG_PRESC_HI, 8'h00, 1'b0, 1'b0), 1'b1,
            reset_res({5'd0, PRESC_HI_RST}));
    add_row(mk_item(CMD_READ, REG_FRAMING, 8'h00, 1'b0, 1'b0), 1'b1, reset_res(FRAMING_RST));
    add_row(mk_item(CMD_READ, REG_DATA, 8'h00, 1'b0, 1'b0), 1'b1, reset_res(8'h00));
    add_row(mk_item(CMD_READ, REG_STATUS, 8'h00, 1'b1, 1'b1), 1'b1, reset_res(8'h12));
    add_row(mk_item(CMD_READ, REG_STATUS, 8'hff, 1'b0, 1'b0), 1'b1, reset_res(8'h00));
    add_row(mk_item(CMD_NONE, REG_STATUS, 8'hff, 1'b1, 1'b1), 1'b1, reset_res(8'h00));
    // prescaler halves and the gated high bits
    add_row(mk_item(CMD_WRITE, REG_DATA, 8'hff, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_DATA, 8'h7f, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_PRESC_HI, 8'h17, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_PRESC_HI, 8'h0f, 1'b0, 1'b0));
    add_row(mk_item(CMD_READ, REG_PRESC_HI, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_DATA, 8'h80, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_DATA, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_PRESC_HI, 8'hf8, 1'b0, 1'b0));
    // framing: odd, even, full byte with clear; then transmit, receive and pops
    add_row(mk_item(CMD_WRITE, REG_FRAMING, 8'h06, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_FRAMING, 8'h04, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_FRAMING, 8'hff, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_STATUS, 8'ha5, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_STATUS, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_RECV, REG_DATA, 8'hff, 1'b0, 1'b0));
    add_row(mk_item(CMD_RECV, REG_DATA, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_READ, REG_STATUS, 8'h00, 1'b1, 1'b0));
    add_row(mk_item(CMD_READ, REG_DATA, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_READ, REG_DATA, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_READ, REG_DATA, 8'h00, 1'b0, 1'b0));
    add_row(mk_item(CMD_WRITE, REG_FRAMING, 8'h18, 1'b0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain_wait();

    mixed_burst(12);
    drain_wait();

    // fill just past near-full while the response side is held off
    hold_asked++;
    fill_fifo(NEAR_LEVEL, NEAR_LEVEL + 2);
    // pop back below near-full
    pop_burst(10);
    drain_wait();

    mixed_burst(12);
    drain_wait();
    repeat (8) @(posedge clk);

    if (n_fail == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
